// ===== src/lag_pkg.sv =====
// ----------------------------------------------------------------------------
// lag_pkg
// shared types, constants and rule functions of the life automaton engine
// ----------------------------------------------------------------------------
package lag_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIM_W  = 9;
    localparam int THR_W  = 4;
    localparam int CNT_W  = 4;
    localparam int WCMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int HCMP_W = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVING_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRO_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DYING_THR   = 3'd4;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 9'd64;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 9'd64;
    localparam logic [THR_W-1:0] RST_LIVING_THR  = 4'd2;
    localparam logic [THR_W-1:0] RST_REPRO_THR   = 4'd3;
    localparam logic [THR_W-1:0] RST_DYING_THR   = 4'd4;

    typedef struct packed {
        logic [DIM_W-1:0] grid_width;
        logic [DIM_W-1:0] grid_height;
        logic [THR_W-1:0] living_thr;
        logic [THR_W-1:0] repro_thr;
        logic [THR_W-1:0] dying_thr;
    } t_cfg;

    // result slots: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
    typedef struct packed {
        logic [3:0]       mask;
        logic [3:0]       alive;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_job;

    // drop the oldest window column, a dead column enters
    function automatic logic [8:0] win_left(input logic [8:0] w);
        win_left = {3'b000, w[8:3]};
    endfunction

    // drop the top window row, a dead row enters
    function automatic logic [8:0] win_up(input logic [8:0] w);
        win_up = {1'b0, w[8:7], 1'b0, w[5:4], 1'b0, w[2:1]};
    endfunction

    function automatic logic life_rule(input logic [8:0] nb, input t_cfg cfg);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                cnt = cnt + CNT_W'(nb[i]);
            end
        end
        if (cnt < cfg.living_thr) begin
            life_rule = 1'b0;
        end else if (cnt < cfg.repro_thr) begin
            life_rule = nb[4];
        end else if (cnt < cfg.dying_thr) begin
            life_rule = 1'b1;
        end else begin
            life_rule = 1'b0;
        end
    endfunction

endpackage

// ===== src/lag_front.sv =====
// ----------------------------------------------------------------------------
// lag_front
// takes cells, tracks the raster position, keeps line buffers and the 3x3
// window, and turns each cell into a job of up to four next-state results
// ----------------------------------------------------------------------------
module lag_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_cell_alive,
    input  lag_pkg::t_cfg        i_cfg,
    output logic                 o_q_push,
    output lag_pkg::t_job        o_q_job,
    input  logic                 i_q_full
);

    typedef struct packed {
        logic                          alive;
        logic [lag_pkg::ROW_W-1:0]     row;
        logic [lag_pkg::COL_W-1:0]     col;
        logic                          row_end;
        logic                          last_row;
    } t_s1;

    logic [lag_pkg::ROW_W-1:0]  r_in_row, n_in_row;
    logic [lag_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic                       r_s1_valid, n_s1_valid;
    t_s1                        r_s1, n_s1;
    logic [8:0]                 r_win, n_win;
    logic [1:0]                 r_rd;
    logic [1:0]                 r_line_mem [0:lag_pkg::MAX_WIDTH-1];

    logic [lag_pkg::WCMP_W-1:0] w_eff, col_x;
    logic [lag_pkg::HCMP_W-1:0] h_eff, row_x;
    logic                       accept, fire;
    logic                       above1, above2;
    logic [8:0]                 base;

    assign full   = r_s1_valid & i_q_full;
    assign accept = push & ~full;
    assign fire   = r_s1_valid & ~i_q_full;

    // position of the incoming cell
    always_comb begin
        w_eff = lag_pkg::WCMP_W'(i_cfg.grid_width);
        if (w_eff < lag_pkg::WCMP_W'(2)) begin
            w_eff = lag_pkg::WCMP_W'(2);
        end else if (w_eff > lag_pkg::WCMP_W'(lag_pkg::MAX_WIDTH)) begin
            w_eff = lag_pkg::WCMP_W'(lag_pkg::MAX_WIDTH);
        end
        h_eff = lag_pkg::HCMP_W'(i_cfg.grid_height);
        if (h_eff < lag_pkg::HCMP_W'(2)) begin
            h_eff = lag_pkg::HCMP_W'(2);
        end else if (h_eff > lag_pkg::HCMP_W'(lag_pkg::MAX_HEIGHT)) begin
            h_eff = lag_pkg::HCMP_W'(lag_pkg::MAX_HEIGHT);
        end

        col_x = lag_pkg::WCMP_W'(r_in_col);
        row_x = lag_pkg::HCMP_W'(r_in_row);
        if (col_x >= w_eff) begin
            col_x = '0;
            row_x = row_x + lag_pkg::HCMP_W'(1);
        end
        if (row_x >= h_eff) begin
            row_x = '0;
        end

        n_s1.alive    = i_cell_alive;
        n_s1.row      = row_x[lag_pkg::ROW_W-1:0];
        n_s1.col      = col_x[lag_pkg::COL_W-1:0];
        n_s1.row_end  = (col_x == w_eff - lag_pkg::WCMP_W'(1));
        n_s1.last_row = (row_x == h_eff - lag_pkg::HCMP_W'(1));

        if (n_s1.row_end) begin
            n_in_col = '0;
            n_in_row = n_s1.last_row ? '0 : n_s1.row + lag_pkg::ROW_W'(1);
        end else begin
            n_in_col = n_s1.col + lag_pkg::COL_W'(1);
            n_in_row = n_s1.row;
        end
    end

    always_comb begin
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (fire) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // window update and job build
    always_comb begin
        above2 = (r_s1.row >= lag_pkg::ROW_W'(2)) ? r_rd[1] : 1'b0;
        above1 = (r_s1.row >= lag_pkg::ROW_W'(1)) ? r_rd[0] : 1'b0;
        base   = (r_s1.col == '0) ? 9'd0 : r_win;
        n_win  = {r_s1.alive, above1, above2, base[8:3]};

        o_q_job.row      = r_s1.row;
        o_q_job.col      = r_s1.col;
        o_q_job.mask[0]  = (r_s1.row != '0) & (r_s1.col != '0);
        o_q_job.mask[1]  = (r_s1.row != '0) & r_s1.row_end;
        o_q_job.mask[2]  = r_s1.last_row & (r_s1.col != '0);
        o_q_job.mask[3]  = r_s1.last_row & r_s1.row_end;
        o_q_job.alive[0] = lag_pkg::life_rule(n_win, i_cfg);
        o_q_job.alive[1] = lag_pkg::life_rule(lag_pkg::win_left(n_win), i_cfg);
        o_q_job.alive[2] = lag_pkg::life_rule(lag_pkg::win_up(n_win), i_cfg);
        o_q_job.alive[3] = lag_pkg::life_rule(
                               lag_pkg::win_up(lag_pkg::win_left(n_win)), i_cfg);
    end

    assign o_q_push = fire & (o_q_job.mask != 4'b0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (accept) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
            end
            if (fire) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // line buffers: bit 1 two rows up, bit 0 one row up
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line_mem[n_s1.col];
        end
        if (fire) begin
            r_line_mem[r_s1.col] <= {r_rd[0], r_s1.alive};
        end
    end

    a_push_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (o_q_job.mask != 4'b0000) && !i_q_full)
        else $error("job pushed without results or into a full queue");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && i_q_full) |=> (r_s1_valid && $stable(r_s1.col) && $stable(r_win)))
        else $error("stalled cell lost its position or window");

endmodule

// ===== src/lag_fifo.sv =====
// ----------------------------------------------------------------------------
// lag_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module lag_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lag_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output lag_pkg::t_job o_data,
    output logic          o_empty
);

    lag_pkg::t_job                   r_mem [0:lag_pkg::JOB_DEPTH-1];
    logic [lag_pkg::JOB_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [lag_pkg::JOB_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [lag_pkg::JOB_CNT_W-1:0]   r_count, n_count;
    logic                            do_push, do_pop;

    assign o_full  = (r_count == lag_pkg::JOB_CNT_W'(lag_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + lag_pkg::JOB_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + lag_pkg::JOB_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + lag_pkg::JOB_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - lag_pkg::JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lag_pkg::JOB_CNT_W'(lag_pkg::JOB_DEPTH))
        else $error("job queue count out of range");

endmodule

// ===== src/lag_back.sv =====
// ----------------------------------------------------------------------------
// lag_back
// takes jobs from the queue and hands out their results one per pop
// ----------------------------------------------------------------------------
module lag_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lag_pkg::t_job                i_q_job,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_next_alive,
    output logic [lag_pkg::POS_W-1:0]    o_cell_row,
    output logic [lag_pkg::POS_W-1:0]    o_cell_col,
    output logic                         o_last_of_run
);

    logic          r_busy, n_busy;
    lag_pkg::t_job r_job, n_job;
    logic [3:0]    sel, rest;
    logic          take, load;

    logic [lag_pkg::ROW_W-1:0] row_up;
    logic [lag_pkg::COL_W-1:0] col_left;

    assign empty = ~r_busy;
    assign take  = pop & r_busy;

    always_comb begin
        sel      = r_job.mask & (~r_job.mask + 4'd1);
        rest     = r_job.mask & ~sel;
        row_up   = r_job.row - lag_pkg::ROW_W'(1);
        col_left = r_job.col - lag_pkg::COL_W'(1);

        o_next_alive  = |(r_job.alive & sel);
        o_last_of_run = (rest == 4'b0000);
        o_cell_row    = (sel[0] | sel[1]) ? lag_pkg::POS_W'(row_up)
                                          : lag_pkg::POS_W'(r_job.row);
        o_cell_col    = (sel[0] | sel[2]) ? lag_pkg::POS_W'(col_left)
                                          : lag_pkg::POS_W'(r_job.col);

        load  = ~r_busy | (take & (rest == 4'b0000));
        o_q_pop = load & ~i_q_empty;

        n_busy = r_busy;
        n_job  = r_job;
        if (load) begin
            n_busy = ~i_q_empty;
            n_job  = i_q_job;
        end else if (take) begin
            n_job.mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.mask != 4'b0000))
        else $error("result shown from a job with nothing left");

endmodule

// ===== src/life_automaton_generation_top.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_top
// streaming next-generation engine for a two-state life-like automaton
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  cells in  push / full      i_cell_alive
//  results   empty / pop      o_next_alive, o_cell_row, o_cell_col, o_last_of_run
//  config    i_cfg_we         i_cfg_idx, i_cfg_data
//
//  one cell is taken per cycle unless full; results leave one per cycle while
//  pop is held, up to four per cell, via front register, job queue and job register
//  a four-entry job queue decouples cell intake from result delivery
//  full rises only while the queue is full and a cell waits to enter it
//  reset clears position, window and queue; line buffer contents are not cleared
// ----------------------------------------------------------------------------
module life_automaton_generation_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_cell_alive,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_next_alive,
    output logic [lag_pkg::POS_W-1:0]         o_cell_row,
    output logic [lag_pkg::POS_W-1:0]         o_cell_col,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_we,
    input  logic [lag_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lag_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lag_pkg::t_cfg r_cfg, n_cfg;
    lag_pkg::t_job q_in_job, q_out_job;
    logic          q_push, q_full, q_pop, q_empty;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                lag_pkg::CFG_GRID_WIDTH: begin
                    n_cfg.grid_width = lag_pkg::DIM_W'(i_cfg_data);
                end
                lag_pkg::CFG_GRID_HEIGHT: begin
                    n_cfg.grid_height = lag_pkg::DIM_W'(i_cfg_data);
                end
                lag_pkg::CFG_LIVING_THR: begin
                    n_cfg.living_thr = i_cfg_data[lag_pkg::THR_W-1:0];
                end
                lag_pkg::CFG_REPRO_THR: begin
                    n_cfg.repro_thr = i_cfg_data[lag_pkg::THR_W-1:0];
                end
                lag_pkg::CFG_DYING_THR: begin
                    n_cfg.dying_thr = i_cfg_data[lag_pkg::THR_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= lag_pkg::RST_GRID_WIDTH;
            r_cfg.grid_height <= lag_pkg::RST_GRID_HEIGHT;
            r_cfg.living_thr  <= lag_pkg::RST_LIVING_THR;
            r_cfg.repro_thr   <= lag_pkg::RST_REPRO_THR;
            r_cfg.dying_thr   <= lag_pkg::RST_DYING_THR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lag_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cell_alive (i_cell_alive),
        .i_cfg        (r_cfg),
        .o_q_push     (q_push),
        .o_q_job      (q_in_job),
        .i_q_full     (q_full)
    );

    lag_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_job),
        .o_empty (q_empty)
    );

    lag_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_job       (q_out_job),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_next_alive  (o_next_alive),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/tb_life_automaton_generation_top.sv =====
// ----------------------------------------------------------------------------
// tb_life_automaton_generation_top
// self-checking bench for the streaming next-generation engine: cells go in
// through the push port, a board model in the bench works out every emitted
// next-state cell, and each popped result is compared field by field
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [lag_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic                      alive;
        logic [lag_pkg::POS_W-1:0] row;
        logic [lag_pkg::POS_W-1:0] col;
        logic                      last;
    } t_gen_cell;

    class next_gen_board;
        logic [lag_pkg::DIM_W-1:0] width_reg;
        logic [lag_pkg::DIM_W-1:0] height_reg;
        logic [lag_pkg::THR_W-1:0] live_thr;
        logic [lag_pkg::THR_W-1:0] repro_thr;
        logic [lag_pkg::THR_W-1:0] dying_thr;
        bit                        older_row [lag_pkg::MAX_WIDTH];
        bit                        newer_row [lag_pkg::MAX_WIDTH];
        bit [8:0]                  window;
        int                        row_pos;
        int                        col_pos;
        t_gen_cell                 next_gen_cells [$];
        int                        mismatches;
        int                        cells_taken;
        int                        results_checked;

        function new();
            width_reg  = lag_pkg::RST_GRID_WIDTH;
            height_reg = lag_pkg::RST_GRID_HEIGHT;
            live_thr   = lag_pkg::RST_LIVING_THR;
            repro_thr  = lag_pkg::RST_REPRO_THR;
            dying_thr  = lag_pkg::RST_DYING_THR;
            window     = '0;
            row_pos    = 0;
            col_pos    = 0;
            mismatches = 0;
            cells_taken = 0;
            results_checked = 0;
        endfunction

        function void set_reg(logic [lag_pkg::CFG_IDX_W-1:0] idx,
                              logic [lag_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lag_pkg::CFG_GRID_WIDTH: begin
                    width_reg = data[lag_pkg::DIM_W-1:0];
                end
                lag_pkg::CFG_GRID_HEIGHT: begin
                    height_reg = data[lag_pkg::DIM_W-1:0];
                end
                lag_pkg::CFG_LIVING_THR: begin
                    live_thr = data[lag_pkg::THR_W-1:0];
                end
                lag_pkg::CFG_REPRO_THR: begin
                    repro_thr = data[lag_pkg::THR_W-1:0];
                end
                lag_pkg::CFG_DYING_THR: begin
                    dying_thr = data[lag_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int clamp_dim(logic [lag_pkg::DIM_W-1:0] v, int hi);
            if (v < 2) begin
                return 2;
            end
            if (v > hi) begin
                return hi;
            end
            return int'(v);
        endfunction

        function int frame_cells();
            return clamp_dim(width_reg, lag_pkg::MAX_WIDTH) *
                   clamp_dim(height_reg, lag_pkg::MAX_HEIGHT);
        endfunction

        // window column 0 is the oldest, row 0 the top; outside is dead
        function bit window_bit(int wc, int wr);
            if (wc > 2 || wr > 2) begin
                return 1'b0;
            end
            return window[wc * 3 + wr];
        endfunction

        function bit rule_at(int c0, int r0);
            int count;
            count = 0;
            for (int dy = 0; dy < 3; dy++) begin
                for (int dx = 0; dx < 3; dx++) begin
                    if (!(dx == 1 && dy == 1)) begin
                        count += window_bit(c0 + dx, r0 + dy);
                    end
                end
            end
            if (count < live_thr) begin
                return 1'b0;
            end
            if (count < repro_thr) begin
                return window_bit(c0 + 1, r0 + 1);
            end
            if (count < dying_thr) begin
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void add_result(bit alive, int row, int col);
            next_gen_cells.insert(next_gen_cells.size(),
                t_gen_cell'{alive, lag_pkg::POS_W'(row), lag_pkg::POS_W'(col), 1'b0});
        endfunction

        function void take_cell(bit alive_in);
            int  w;
            int  h;
            int  n;
            bit  above2;
            bit  above1;
            bit  row_end;
            bit  last_row;
            w = clamp_dim(width_reg, lag_pkg::MAX_WIDTH);
            h = clamp_dim(height_reg, lag_pkg::MAX_HEIGHT);
            n = 0;
            cells_taken++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) begin
                row_pos = 0;
            end
            above2 = (row_pos >= 2) ? older_row[col_pos] : 1'b0;
            above1 = (row_pos >= 1) ? newer_row[col_pos] : 1'b0;
            older_row[col_pos] = newer_row[col_pos];
            newer_row[col_pos] = alive_in;
            if (col_pos == 0) begin
                window = '0;
            end
            window = {alive_in, above1, above2, window[8:3]};
            row_end  = (col_pos == w - 1);
            last_row = (row_pos == h - 1);
            if (row_pos >= 1 && col_pos >= 1) begin
                add_result(rule_at(0, 0), row_pos - 1, col_pos - 1);
                n++;
            end
            if (row_pos >= 1 && row_end) begin
                add_result(rule_at(1, 0), row_pos - 1, col_pos);
                n++;
            end
            if (last_row && col_pos >= 1) begin
                add_result(rule_at(0, 1), row_pos, col_pos - 1);
                n++;
            end
            if (last_row && row_end) begin
                add_result(rule_at(1, 1), row_pos, col_pos);
                n++;
            end
            if (n > 0) begin
                next_gen_cells[next_gen_cells.size() - 1].last = 1'b1;
            end
            if (row_end) begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        endfunction

        function void check_result(t_gen_cell got);
            t_gen_cell want;
            results_checked++;
            if (next_gen_cells.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected result: alive=%0b row=%0d col=%0d last=%0b",
                             $realtime, got.alive, got.row, got.col, got.last);
                end
                return;
            end
            want = next_gen_cells.pop_front();
            if (got.alive !== want.alive || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch: expected alive=%0b row=%0d col=%0d last=%0b",
                             $realtime, want.alive, want.row, want.col, want.last);
                    $display("[%0t]          actual   alive=%0b row=%0d col=%0d last=%0b",
                             $realtime, got.alive, got.row, got.col, got.last);
                end
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           i_cell_alive = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_next_alive;
    logic [lag_pkg::POS_W-1:0]      o_cell_row;
    logic [lag_pkg::POS_W-1:0]      o_cell_col;
    logic                           o_last_of_run;
    logic                           i_cfg_we = 1'b0;
    logic [lag_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lag_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    next_gen_board board = new();
    bit            steady = 1'b0;
    int            cycle_count = 0;
    int            settings_used = 0;

    life_automaton_generation_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cell_alive  (i_cell_alive),
        .empty         (empty),
        .pop           (pop),
        .o_next_alive  (o_next_alive),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result(t_gen_cell'{o_next_alive, o_cell_row, o_cell_col,
                                           o_last_of_run});
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cell(input bit v);
        while (!steady && $urandom_range(0, 99) < 36) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_cell_alive <= v;
        do begin
            @(posedge i_clk);
        end while (full);
        board.take_cell(v);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count, input int density);
        repeat (count) begin
            send_cell($urandom_range(0, 99) < density);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        @(negedge i_clk);
        while (board.next_gen_cells.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lag_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        board.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [lag_pkg::DIM_W-1:0] w,
                             input logic [lag_pkg::DIM_W-1:0] h,
                             input logic [lag_pkg::THR_W-1:0] lt,
                             input logic [lag_pkg::THR_W-1:0] rt,
                             input logic [lag_pkg::THR_W-1:0] dt);
        settle();
        settings_used++;
        write_reg(lag_pkg::CFG_GRID_WIDTH, w);
        write_reg(lag_pkg::CFG_GRID_HEIGHT, h);
        write_reg(lag_pkg::CFG_LIVING_THR, lag_pkg::CFG_DATA_W'(lt));
        write_reg(lag_pkg::CFG_REPRO_THR, lag_pkg::CFG_DATA_W'(rt));
        write_reg(lag_pkg::CFG_DYING_THR, lag_pkg::CFG_DATA_W'(dt));
    endtask

    initial begin
        int random_cells;
        bit standard_rule;
        random_cells = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // width and height below range, thresholds at the extremes
        configure(9'd0, 9'd1, 4'd0, 4'd9, 4'd15);
        repeat (4) send_cell(1'b1);

        // high data bits are dropped, unused index has no effect
        configure(9'd1, 9'd0, 4'd2, 4'd3, 4'd4);
        write_reg(lag_pkg::CFG_LIVING_THR, 9'h1F2);
        write_reg(CFG_UNUSED_IDX, 9'h1FF);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b1);

        // every threshold out of reach of any count
        configure(9'd3, 9'd3, 4'd15, 4'd15, 4'd15);
        repeat (9) send_cell(1'b1);

        // width shrunk mid-frame wraps to the next row
        configure(9'd4, 9'd3, 4'd2, 4'd3, 4'd4);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b1);
        send_cell(1'b1);
        settle();
        write_reg(lag_pkg::CFG_GRID_WIDTH, 9'd2);
        send_cell(1'b0);
        send_cell(1'b1);

        while (random_cells < 40) begin
            standard_rule = $urandom_range(0, 1);
            if (standard_rule) begin
                configure(9'($urandom_range(0, 10)), 9'($urandom_range(0, 6)),
                          4'd2, 4'd3, 4'd4);
            end else begin
                configure(9'($urandom_range(0, 10)), 9'($urandom_range(0, 6)),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)));
            end
            random_cells += board.frame_cells();
            send_random(board.frame_cells(), $urandom_range(5, 95));
        end

        // widest setting with no idling, then both dimensions shrunk mid-frame
        steady = 1'b1;
        configure(9'd511, 9'd3, 4'd2, 4'd3, 4'd4);
        send_random(24, 50);
        settle();
        write_reg(lag_pkg::CFG_GRID_WIDTH, 9'd2);
        write_reg(lag_pkg::CFG_GRID_HEIGHT, 9'd2);
        steady = 1'b0;
        send_random(4, 50);

        // tallest setting, cut short by a height shrink
        configure(9'd2, 9'd511, 4'd1, 4'd2, 4'd5);
        send_random(6, 60);
        settle();
        write_reg(lag_pkg::CFG_GRID_HEIGHT, 9'd2);
        send_random(4, 40);

        settle();
        $display("%0d cells sent under %0d grid and rule settings, %0d results checked",
                 board.cells_taken, settings_used, board.results_checked);
        $display("%0d mismatches, %0d results still missing",
                 board.mismatches, board.next_gen_cells.size());
        if (board.mismatches == 0 && board.next_gen_cells.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/lag_pkg.sv
src/lag_front.sv
src/lag_fifo.sv
src/lag_back.sv
src/life_automaton_generation_top.sv
tb/tb_life_automaton_generation_top.sv
